@@ sv/cbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types, constants and CORDIC angle table for the circle sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_RADIUS      = 2'd2,
        REG_POINT_COUNT = 2'd3
    } cfg_reg_t;

    localparam int NUM_W  = 36;   // divider dividend / quotient width
    localparam int DEN_W  = 33;   // divider divisor width
    localparam int TURN_W = 20;   // 2*pi/n in Q16.16 stays below 2^19 for n >= 1
    localparam int XY_W   = 32;   // CORDIC vector, Q2.30
    localparam int Z_W    = 34;   // CORDIC residual angle, 2^-32 turn

    localparam logic [NUM_W-1:0] TWO_PI_Q32 = 36'd26986075409;
    localparam logic [NUM_W-1:0] ONE_Q32    = 36'h1_0000_0000;
    localparam logic signed [XY_W-1:0] CORDIC_X0 = 32'sd652032874;

    localparam logic [31:0]       PHASE_STEP_RST = 32'd67108864;
    localparam logic [TURN_W-1:0] TURN_STEP_RST  = 20'd6434;
    localparam logic [31:0]       INV_RADIUS_RST = 32'd65536;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } clip_t;

    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] a;
        case (k)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // clip a signed value to the signed 32-bit range
    function automatic clip_t clip32(input logic signed [63:0] v);
        clip_t r;
        if (v > 64'sd2147483647)
        begin
            r.val  = 32'h7FFF_FFFF;
            r.clip = 1'b1;
        end
        else if (v < -64'sd2147483648)
        begin
            r.val  = 32'h8000_0000;
            r.clip = 1'b1;
        end
        else
        begin
            r.val  = v[31:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/cbs_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbs_div
    import cbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift into the dividend register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
    end

    assign rsp.busy = run_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule
`default_nettype wire

@@ sv/circle_boundary_sampler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// circle_boundary_sampler
// Point, scaled normal and curvature of a circle at sample i of n, CORDIC based.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_*       in   request: point_index
// m_*       out  result: point_x, point_y, normal_x, normal_y, curvature; saturated
// cfg_*     in   register write: center_x, center_y, radius, point_count
//
// One request per cycle while s_tready is high; registered steps in order: phase multiply,
// CORDIC stages, quadrant fold, radius multiply, rounding, step multiply, output.
// A register write recomputes phase step, turn step and 1/radius on one serial
// divider, with s_tready low meanwhile.
// Output side has a two-entry buffer; the pipeline stalls as a whole only when
// its spare entry is full.
// ----------------------------------------------------------------------------
module circle_boundary_sampler
    import cbs_pkg::*;
#(
    parameter int MAX_POINTS    = 4096,
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [11:0] point_index
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,   // point_x, point_y, normal_x, normal_y, curvature
    output logic              m_tuser,   // saturated
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    localparam int N_W = $clog2(MAX_POINTS + 1);
    localparam int S   = CORDIC_STAGES;

    typedef enum logic [1:0] { D_IDLE, D_START, D_WAIT } dstate_t;
    typedef enum logic [1:0] { JOB_PHASE, JOB_TURN, JOB_INV } job_t;

    // ---------------- configuration and derived values ----------------
    logic signed [31:0] center_x_reg, center_y_reg;
    logic [30:0]        radius_reg;
    logic [12:0]        point_count_reg;
    logic [31:0]        phase_step_reg;
    logic [TURN_W-1:0]  turn_step_reg;
    logic [31:0]        inv_radius_reg;
    logic               inv_clip_reg;
    dstate_t            dstate_reg;
    job_t               job_reg;

    logic [N_W-1:0]     n_eff;
    logic [30:0]        r_eff;
    div_req_t           dreq;
    div_rsp_t           drsp;

    always_comb
    begin
        if (point_count_reg == 13'd0)
            n_eff = N_W'(1);
        else if (32'(point_count_reg) > 32'(MAX_POINTS))
            n_eff = N_W'(MAX_POINTS);
        else
            n_eff = N_W'(point_count_reg);
        r_eff = (radius_reg == 31'd0) ? 31'd1 : radius_reg;
    end

    always_comb
    begin
        dreq.start = (dstate_reg == D_START);
        case (job_reg)
            JOB_PHASE:
            begin
                dreq.num = ONE_Q32 + NUM_W'(n_eff >> 1);
                dreq.den = DEN_W'(n_eff);
            end
            JOB_TURN:
            begin
                dreq.num = TWO_PI_Q32 + (NUM_W'(n_eff) << 15);
                dreq.den = DEN_W'(n_eff) << 16;
            end
            default:
            begin
                dreq.num = ONE_Q32 + NUM_W'(r_eff >> 1);
                dreq.den = DEN_W'(r_eff);
            end
        endcase
    end

    cbs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            radius_reg      <= 31'd65536;
            point_count_reg <= 13'd64;
            phase_step_reg  <= PHASE_STEP_RST;
            turn_step_reg   <= TURN_STEP_RST;
            inv_radius_reg  <= INV_RADIUS_RST;
            inv_clip_reg    <= 1'b0;
            dstate_reg      <= D_IDLE;
            job_reg         <= JOB_PHASE;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CENTER_X:    center_x_reg    <= cfg_wdata;
                REG_CENTER_Y:    center_y_reg    <= cfg_wdata;
                REG_RADIUS:      radius_reg      <= cfg_wdata[30:0];
                REG_POINT_COUNT: point_count_reg <= cfg_wdata[12:0];
                default:         center_x_reg    <= center_x_reg;
            endcase
            // restart the derivation sequence
            dstate_reg <= D_START;
            job_reg    <= JOB_PHASE;
        end
        else
        begin
            case (dstate_reg)
                D_START: dstate_reg <= D_WAIT;
                D_WAIT:
                begin
                    if (drsp.done)
                    begin
                        case (job_reg)
                            JOB_PHASE:
                            begin
                                phase_step_reg <= drsp.quot[31:0];
                                job_reg        <= JOB_TURN;
                                dstate_reg     <= D_START;
                            end
                            JOB_TURN:
                            begin
                                turn_step_reg <= drsp.quot[TURN_W-1:0];
                                job_reg       <= JOB_INV;
                                dstate_reg    <= D_START;
                            end
                            default:
                            begin
                                inv_clip_reg   <= |drsp.quot[NUM_W-1:32];
                                inv_radius_reg <= (|drsp.quot[NUM_W-1:32]) ?
                                                  32'hFFFF_FFFF : drsp.quot[31:0];
                                dstate_reg     <= D_IDLE;
                            end
                        endcase
                    end
                end
                default: dstate_reg <= D_IDLE;
            endcase
        end
    end

    // ---------------- pipeline ----------------
    logic skid_valid_reg;
    logic en;
    logic acc;

    assign en       = !skid_valid_reg;
    assign s_tready = en && (dstate_reg == D_IDLE);
    assign acc      = s_tvalid && s_tready;

    // phase = i * step mod 2^32
    logic        va_reg;
    logic [31:0] phase_reg;
    logic [43:0] phase_full;

    assign phase_full = s_tdata[11:0] * phase_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            phase_reg <= phase_full[31:0];
    end

    // CORDIC rotation, one stage per register
    logic                  cv [0:S];
    logic signed [XY_W-1:0] cx [0:S];
    logic signed [XY_W-1:0] cy [0:S];
    logic signed [Z_W-1:0]  cz [0:S];
    logic [1:0]             cq [0:S];

    assign cv[0] = va_reg;
    assign cx[0] = CORDIC_X0;
    assign cy[0] = '0;
    assign cz[0] = Z_W'(phase_reg[29:0]);
    assign cq[0] = phase_reg[31:30];

    for (genvar k = 0; k < S; k++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv[k+1] <= 1'b0;
            else if (en)
                cv[k+1] <= cv[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cq[k+1] <= cq[k];
                if (!cz[k][Z_W-1])
                begin
                    cx[k+1] <= cx[k] - (cy[k] >>> k);
                    cy[k+1] <= cy[k] + (cx[k] >>> k);
                    cz[k+1] <= cz[k] - $signed(Z_W'(atan_turn(k)));
                end
                else
                begin
                    cx[k+1] <= cx[k] + (cy[k] >>> k);
                    cy[k+1] <= cy[k] - (cx[k] >>> k);
                    cz[k+1] <= cz[k] + $signed(Z_W'(atan_turn(k)));
                end
            end
        end
    end

    // quadrant fold
    logic                   vq_reg;
    logic signed [XY_W-1:0] c_reg, s_reg;

    // radius multiply
    logic                   vm_reg;
    logic signed [63:0]     px_reg, py_reg;
    logic signed [31:0]     r_s;

    // rounding to Q16.16 offset
    logic                   vd_reg;
    logic signed [33:0]     dx_reg, dy_reg;
    logic signed [63:0]     rx, ry;

    // point and normal product
    logic                   vn_reg;
    logic [31:0]            pxo_reg, pyo_reg;
    logic                   pflag_reg;
    logic signed [63:0]     nx_reg, ny_reg;
    logic signed [TURN_W:0] ts_s;
    clip_t                  clx, cly;

    // final normal
    logic signed [63:0]     nrx, nry;
    clip_t                  cnx, cny;
    logic [159:0]           res_data;
    logic                   res_flag;
    logic                   push;

    assign r_s  = $signed({1'b0, r_eff});
    assign rx   = px_reg + 64'sd536870912;
    assign ry   = py_reg + 64'sd536870912;
    assign ts_s = $signed({1'b0, turn_step_reg});
    assign clx  = clip32(64'(center_x_reg) + 64'(dx_reg));
    assign cly  = clip32(64'(center_y_reg) + 64'(dy_reg));
    assign nrx  = nx_reg + 64'sd32768;
    assign nry  = ny_reg + 64'sd32768;
    assign cnx  = clip32(nrx >>> 16);
    assign cny  = clip32(nry >>> 16);

    assign res_data = {inv_radius_reg, cny.val, cnx.val, pyo_reg, pxo_reg};
    assign res_flag = pflag_reg | cnx.clip | cny.clip;
    assign push     = en && vn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vm_reg <= 1'b0;
            vd_reg <= 1'b0;
            vn_reg <= 1'b0;
        end
        else if (en)
        begin
            vq_reg <= cv[S];
            vm_reg <= vq_reg;
            vd_reg <= vm_reg;
            vn_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (cq[S])
                2'd0:
                begin
                    c_reg <= cx[S];
                    s_reg <= cy[S];
                end
                2'd1:
                begin
                    c_reg <= -cy[S];
                    s_reg <= cx[S];
                end
                2'd2:
                begin
                    c_reg <= -cx[S];
                    s_reg <= -cy[S];
                end
                default:
                begin
                    c_reg <= cy[S];
                    s_reg <= -cx[S];
                end
            endcase
            px_reg    <= r_s * c_reg;
            py_reg    <= r_s * s_reg;
            dx_reg    <= 34'(rx >>> 30);
            dy_reg    <= 34'(ry >>> 30);
            pxo_reg   <= clx.val;
            pyo_reg   <= cly.val;
            pflag_reg <= inv_clip_reg | clx.clip | cly.clip;
            nx_reg    <= 64'(dx_reg * ts_s);
            ny_reg    <= 64'(dy_reg * ts_s);
        end
    end

    // ---------------- output buffer ----------------
    logic         out_valid_reg;
    logic [159:0] out_data_reg, skid_data_reg;
    logic         out_flag_reg, skid_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= push;
        end
        else if (out_valid_reg)
        begin
            if (push)
                skid_valid_reg <= 1'b1;
        end
        else
        begin
            out_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_flag_reg <= skid_flag_reg;
            end
            else if (push)
            begin
                out_data_reg <= res_data;
                out_flag_reg <= res_flag;
            end
        end
        else if (out_valid_reg)
        begin
            // hold the waiting result, park the new one
            if (push)
            begin
                skid_data_reg <= res_data;
                skid_flag_reg <= res_flag;
            end
        end
        else if (push)
        begin
            out_data_reg <= res_data;
            out_flag_reg <= res_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

    // ---------------- assertions ----------------
    a_no_req_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (dstate_reg == D_IDLE))
        else $error("request taken while derived values are stale");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("input open right after a register write");

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("spare entry full with empty output register");

    a_divider_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (dstate_reg == D_WAIT) || $past(cfg_we))
        else $error("divider finished outside a derivation step");

endmodule
`default_nettype wire

@@ sim/tb_circle_boundary_sampler.sv @@
// ----------------------------------------------------------------------------
// tb_circle_boundary_sampler
// Drives sample indexes through the circle sampler and checks every result
// field against a fixed-point CORDIC predictor held in the bench.
// ----------------------------------------------------------------------------
module tb_circle_boundary_sampler
    import cbs_pkg::*;
;

    typedef struct packed {
        logic        sat;
        logic [31:0] curv;
        logic [31:0] ny;
        logic [31:0] nx;
        logic [31:0] py;
        logic [31:0] px;
    } sample_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    circle_boundary_sampler dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor copy of the configuration and derived state
    longint   ctr_x, ctr_y;
    longint   rad;
    longint   npts;
    longint   turn_step_q, phase_step_q, inv_rad;
    bit       inv_clip;

    sample_t  expected_samples[$];
    int       mismatches;
    int       send_idle_pct, recv_stall_pct;
    int       quiet_cycles;
    int       atan_tbl[32];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint floor_sh(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint sat32(longint v, inout bit f);
        if (v > 64'sd2147483647)
        begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    task automatic recompute_derived();
        longint n, r, inv;
        n = (npts == 0) ? 1 : npts;
        if (n > 4096)
            n = 4096;
        r = (rad == 0) ? 1 : rad;
        turn_step_q  = (64'd26986075409 + n * 32768) / (n * 65536);
        phase_step_q = ((64'd1 << 32) + n / 2) / n;
        phase_step_q &= 64'hFFFF_FFFF;
        inv = ((64'd1 << 32) + r / 2) / r;
        inv_clip = inv > 64'hFFFF_FFFF;
        inv_rad  = inv_clip ? 64'hFFFF_FFFF : inv;
    endtask

    function automatic sample_t predict_sample(logic [11:0] idx);
        sample_t  res;
        bit       f;
        longint   ph, x, y, z, nx2, c, s, dx, dy;
        f  = inv_clip;
        ph = (longint'(idx) * phase_step_q) & 64'hFFFF_FFFF;
        x = 652032874;
        y = 0;
        z = ph & 64'h3FFF_FFFF;
        for (int k = 0; k < 16; k++)
        begin
            if (z >= 0)
            begin
                nx2 = x - floor_sh(y, k);
                y   = y + floor_sh(x, k);
                z  -= atan_tbl[k];
            end
            else
            begin
                nx2 = x + floor_sh(y, k);
                y   = y - floor_sh(x, k);
                z  += atan_tbl[k];
            end
            x = nx2;
        end
        case (ph >> 30)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        dx = floor_sh(((rad == 0) ? 1 : rad) * c + (64'd1 << 29), 30);
        dy = floor_sh(((rad == 0) ? 1 : rad) * s + (64'd1 << 29), 30);
        res.px   = 32'(sat32(ctr_x + dx, f));
        res.py   = 32'(sat32(ctr_y + dy, f));
        res.nx   = 32'(sat32(floor_sh(dx * turn_step_q + 32768, 16), f));
        res.ny   = 32'(sat32(floor_sh(dy * turn_step_q + 32768, 16), f));
        res.curv = inv_rad[31:0];
        res.sat  = f;
        return res;
    endfunction

    task automatic send_index(logic [11:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_samples.push_back(predict_sample(idx));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (r)
            REG_CENTER_X:    ctr_x = longint'(signed'(v));
            REG_CENTER_Y:    ctr_y = longint'(signed'(v));
            REG_RADIUS:      rad   = v[30:0];
            REG_POINT_COUNT: npts  = v[12:0];
            default:         ;
        endcase
        recompute_derived();
    endtask

    task automatic set_circle(logic [31:0] cx, logic [31:0] cy, logic [30:0] r,
                              logic [12:0] n);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_RADIUS, {1'b0, r});
        write_reg(REG_POINT_COUNT, {19'b0, n});
    endtask

    task automatic test_reset_defaults();
        send_index(12'd0);
        send_index(12'd16);
        send_index(12'd48);
        send_index(12'd64);
        send_index(12'd4095);
    endtask

    task automatic test_extremes();
        // smallest radius overflows the curvature
        set_circle(32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 13'd1);
        send_index(12'd0);
        send_index(12'd4095);
        // zero radius and zero point count
        set_circle(32'h0, 32'h0, 31'd0, 13'd0);
        send_index(12'd5);
        // largest radius at the corners, point count above the maximum
        set_circle(32'h7FFF_0000, 32'h8000_0000, 31'h7FFF_FFFF, 13'h1FFF);
        for (int i = 0; i < 8; i++)
            send_index(12'(i * 512));
        set_circle(32'h0, 32'h0, 31'h7FFF_FFFF, 13'd4096);
        send_index(12'd1024);
        send_index(12'd2048);
        send_index(12'd3072);
        set_circle(32'h0, 32'h0, 31'h7FFF_FFFF, 13'd3);
        send_index(12'd1);
        send_index(12'd2);
        // hold off until everything has come back
        wait_drained();
        send_index(12'd2730);
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        logic [30:0] r;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        r = ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 22));
        set_circle($urandom, $urandom, r, 13'($urandom_range(4097) + 1));
        for (int i = 0; i < count; i++)
            send_index(($urandom_range(1) == 0) ? 12'($urandom_range(npts)) : 12'($urandom));
    endtask

    // result checker and stall generator
    always @(posedge clk)
    begin
        sample_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata};
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h act %h", want, got);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        atan_tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                     83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                     81, 41, 20, 10, 5, 3, 1, 1, 0};
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_wdata = '0;
        mismatches = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ctr_x = 0;
        ctr_y = 0;
        rad = 65536;
        npts = 64;
        recompute_derived();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // idle a while after reset
        repeat (200) @(posedge clk);
        test_reset_defaults();
        test_extremes();
        for (int p = 0; p < 16; p++)
        begin
            case (p % 4)
                0: test_random_phase(0, 0, 120);
                1: test_random_phase(56, 0, 120);
                2: test_random_phase(0, 56, 120);
                default: test_random_phase(12, 12, 120);
            endcase
        end
        wait_drained();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ circle_boundary_sampler.f @@
sv/cbs_pkg.sv
sv/cbs_div.sv
sv/circle_boundary_sampler.sv
sim/tb_circle_boundary_sampler.sv
